@@ rtl/complex_arithmetic_unit_core_assert.svh @@
// Assertion helpers shared by the RTL. Every assertion is clocked on clk_i
// and switched off while rst_ni is low.
`ifndef COMPLEX_ARITHMETIC_UNIT_CORE_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_CORE_ASSERT_SVH

// same-cycle implication
`define CAU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CAU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/cau_pkg.sv @@
`default_nettype none
package cau_pkg;

  // fixed-point format of all operands and results
  localparam int FRAC_BITS = 16;
  // shift that aligns a dividend for a 32-bit quotient
  localparam int KSH       = 32 - FRAC_BITS;
  // quotient and root bits, one per iteration stage
  localparam int NSTEP     = 32;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_MUL   = 3'd2;
  localparam logic [2:0] OP_DIV   = 3'd3;
  localparam logic [2:0] OP_SCALE = 3'd4;
  localparam logic [2:0] OP_MAG   = 3'd5;

  localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  typedef enum logic [2:0] {
    CLS_ADD,
    CLS_SUB,
    CLS_MUL,
    CLS_DIV,
    CLS_SCALE,
    CLS_MAG,
    CLS_NOP
  } cls_e;

  typedef struct packed {
    cls_e        cls;
    logic [31:0] a_re;
    logic [31:0] a_im;
    logic [31:0] b_re;
    logic [31:0] b_im;
  } item_t;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        ovf;
    logic        dz;
  } res_t;

endpackage
`default_nettype wire

@@ rtl/cau_front.sv @@
`default_nettype none
module cau_front
  import cau_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire logic        full_i,
  input  wire logic [2:0]  op_i,
  input  wire logic [31:0] a_re_i,
  input  wire logic [31:0] a_im_i,
  input  wire logic [31:0] b_re_i,
  input  wire logic [31:0] b_im_i,
  output logic             wr_o,
  output item_t            item_o
);

  cls_e cls;

  // classify the opcode; unused codes become a no-op that yields zero
  always_comb begin
    case (op_i)
      OP_ADD:   cls = CLS_ADD;
      OP_SUB:   cls = CLS_SUB;
      OP_MUL:   cls = CLS_MUL;
      OP_DIV:   cls = CLS_DIV;
      OP_SCALE: cls = CLS_SCALE;
      OP_MAG:   cls = CLS_MAG;
      default:  cls = CLS_NOP;
    endcase
  end

  assign wr_o        = push_i && !full_i;
  assign item_o.cls  = cls;
  assign item_o.a_re = a_re_i;
  assign item_o.a_im = a_im_i;
  assign item_o.b_re = b_re_i;
  assign item_o.b_im = b_im_i;

  `include "complex_arithmetic_unit_core_assert.svh"

  `CAU_ASSERT_IMP(a_front_nop, wr_o && (op_i == OP_ADD || op_i == OP_MAG), cls != CLS_NOP, "valid opcode classed as no-op")
  `CAU_ASSERT_IMP(a_front_full, full_i, !wr_o, "write while queue full")
  `CAU_ASSERT_NXT(a_front_rst, !rst_ni, 1'b1, "unreachable")

endmodule
`default_nettype wire

@@ rtl/cau_queue.sv @@
`default_nettype none
module cau_queue
  import cau_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  wr_i,
  input  wire item_t item_i,
  input  wire logic  take_i,
  output logic       full_o,
  output logic       empty_o,
  output item_t      head_o
);

  item_t              mem_q [QDEPTH];
  logic [QAW-1:0]     wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QAW:0]       cnt_q, cnt_d;
  logic               rd;

  assign full_o  = cnt_q == (QAW+1)'(QDEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rptr_q];
  assign rd      = take_i && !empty_o;

  always_comb begin
    wptr_d = wr_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d = rd ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q + (QAW+1)'(wr_i) - (QAW+1)'(rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

@@ rtl/cau_back.sv @@
`default_nettype none
module cau_back
  import cau_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  q_empty_i,
  input  wire item_t q_head_i,
  output logic       take_o,
  input  wire logic  pop_i,
  output logic       empty_o,
  output res_t       res_o
);

  typedef struct packed {
    logic [31:0] val;
    logic        ovf;
  } sat_t;

  typedef struct packed {
    cls_e        cls;
    logic [31:0] sr;
    logic [31:0] si;
    logic        so;
    logic        dz;
    logic        neg_re;
    logic        neg_im;
    logic        big_re;
    logic        big_im;
    logic [63:0] d;
    logic [63:0] r_re;
    logic [63:0] r_im;
    logic [31:0] nl_re;
    logic [31:0] nl_im;
    logic [31:0] q_re;
    logic [31:0] q_im;
    logic [63:0] sx;
    logic [33:0] srem;
    logic [31:0] root;
  } it_t;

  localparam logic signed [32:0] MAX33 = 33'sh7fffffff;
  localparam logic signed [32:0] MIN33 = -33'sh80000000;
  localparam logic signed [64:0] MAX65 = 65'sh7fffffff;
  localparam logic signed [64:0] MIN65 = -65'sh80000000;

  function automatic sat_t sat33(input logic signed [32:0] v);
    sat_t o;
    o.ovf = 1'b1;
    if (v > MAX33) o.val = S32_MAX;
    else if (v < MIN33) o.val = S32_MIN;
    else begin
      o.val = v[31:0];
      o.ovf = 1'b0;
    end
    return o;
  endfunction

  function automatic sat_t sat65(input logic signed [64:0] v);
    sat_t o;
    o.ovf = 1'b1;
    if (v > MAX65) o.val = S32_MAX;
    else if (v < MIN65) o.val = S32_MIN;
    else begin
      o.val = v[31:0];
      o.ovf = 1'b0;
    end
    return o;
  endfunction

  // one restoring-division bit for each part and one root bit
  function automatic it_t step_fn(input it_t s);
    it_t         o;
    logic [64:0] r2r, r2i, dd;
    logic [35:0] trial, tt;
    o   = s;
    dd  = {1'b0, s.d};
    r2r = {s.r_re, s.nl_re[31]};
    r2i = {s.r_im, s.nl_im[31]};
    if (r2r >= dd) begin
      o.r_re = 64'(r2r - dd);
      o.q_re = {s.q_re[30:0], 1'b1};
    end else begin
      o.r_re = r2r[63:0];
      o.q_re = {s.q_re[30:0], 1'b0};
    end
    if (r2i >= dd) begin
      o.r_im = 64'(r2i - dd);
      o.q_im = {s.q_im[30:0], 1'b1};
    end else begin
      o.r_im = r2i[63:0];
      o.q_im = {s.q_im[30:0], 1'b0};
    end
    o.nl_re = {s.nl_re[30:0], 1'b0};
    o.nl_im = {s.nl_im[30:0], 1'b0};
    trial   = {s.srem, s.sx[63:62]};
    tt      = {2'b00, s.root, 2'b01};
    if (trial >= tt) begin
      o.srem = 34'(trial - tt);
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.srem = trial[33:0];
      o.root = {s.root[30:0], 1'b0};
    end
    o.sx = {s.sx[61:0], 2'b00};
    return o;
  endfunction

  function automatic sat_t div_fmt(input logic [31:0] q, input logic neg, input logic big);
    sat_t o;
    if (neg) begin
      o.ovf = big || (q > 32'h8000_0000);
      o.val = o.ovf ? S32_MIN : 32'(-q);
    end else begin
      o.ovf = big || q[31];
      o.val = o.ovf ? S32_MAX : q;
    end
    return o;
  endfunction

  logic adv;

  // stage 1: products, add and subtract
  logic               v1_q;
  cls_e               cls1_q;
  logic signed [63:0] p_arbr_q, p_aibi_q, p_arbi_q, p_aibr_q, p_sq0_q, p_sq1_q;
  logic [31:0]        sr1_q, si1_q;
  logic               so1_q;
  logic signed [31:0] ar, ai, br, bi, x0, x1;
  logic signed [32:0] s_re, s_im;
  sat_t               st_re, st_im;

  always_comb begin
    ar = $signed(q_head_i.a_re);
    ai = $signed(q_head_i.a_im);
    br = $signed(q_head_i.b_re);
    bi = $signed(q_head_i.b_im);
    x0 = (q_head_i.cls == CLS_MAG) ? ar : br;
    x1 = (q_head_i.cls == CLS_MAG) ? ai : bi;
    if (q_head_i.cls == CLS_SUB) begin
      s_re = 33'(ar) - 33'(br);
      s_im = 33'(ai) - 33'(bi);
    end else begin
      s_re = 33'(ar) + 33'(br);
      s_im = 33'(ai) + 33'(bi);
    end
    st_re = sat33(s_re);
    st_im = sat33(s_im);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cls1_q   <= q_head_i.cls;
      p_arbr_q <= ar * br;
      p_aibi_q <= ai * bi;
      p_arbi_q <= ar * bi;
      p_aibr_q <= ai * br;
      p_sq0_q  <= x0 * x0;
      p_sq1_q  <= x1 * x1;
      if (q_head_i.cls == CLS_ADD || q_head_i.cls == CLS_SUB) begin
        sr1_q <= st_re.val;
        si1_q <= st_im.val;
        so1_q <= st_re.ovf | st_im.ovf;
      end else begin
        sr1_q <= '0;
        si1_q <= '0;
        so1_q <= 1'b0;
      end
    end
  end

  // stage 2: sums of products, scaling, sign and magnitude for the divider
  logic               v2_q;
  cls_e               cls2_q;
  logic [63:0]        n_re_q, n_im_q, den_q;
  logic               neg_re_q, neg_im_q;
  logic [31:0]        sr2_q, si2_q;
  logic               so2_q;
  logic signed [64:0] re_y, im_y, re_sum, im_sum, re_neg, im_neg;
  sat_t               m_re, m_im;

  always_comb begin
    re_y   = (cls1_q == CLS_MUL || cls1_q == CLS_DIV) ? 65'(p_aibi_q) : '0;
    im_y   = (cls1_q == CLS_MUL || cls1_q == CLS_DIV) ? 65'(p_arbi_q) : '0;
    re_sum = (cls1_q == CLS_MUL) ? 65'(p_arbr_q) - re_y : 65'(p_arbr_q) + re_y;
    im_sum = (cls1_q == CLS_DIV) ? 65'(p_aibr_q) - im_y : 65'(p_aibr_q) + im_y;
    re_neg = -re_sum;
    im_neg = -im_sum;
    m_re   = sat65(re_sum >>> FRAC_BITS);
    m_im   = sat65(im_sum >>> FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cls2_q   <= cls1_q;
      neg_re_q <= re_sum[64];
      neg_im_q <= im_sum[64];
      n_re_q   <= re_sum[64] ? re_neg[63:0] : re_sum[63:0];
      n_im_q   <= im_sum[64] ? im_neg[63:0] : im_sum[63:0];
      den_q    <= p_sq0_q[63:0] + p_sq1_q[63:0];
      if (cls1_q == CLS_MUL || cls1_q == CLS_SCALE) begin
        sr2_q <= m_re.val;
        si2_q <= m_im.val;
        so2_q <= m_re.ovf | m_im.ovf;
      end else begin
        sr2_q <= sr1_q;
        si2_q <= si1_q;
        so2_q <= so1_q;
      end
    end
  end

  // iteration pipeline: entry 0 is the set-up stage, entry i follows step i
  it_t  it_q  [NSTEP+1];
  logic itv_q [NSTEP+1];
  it_t  it0;
  logic [63:0] al_re, al_im;

  always_comb begin
    al_re      = n_re_q >> KSH;
    al_im      = n_im_q >> KSH;
    it0.cls    = cls2_q;
    it0.sr     = sr2_q;
    it0.si     = si2_q;
    it0.so     = so2_q;
    it0.dz     = den_q == '0;
    it0.neg_re = neg_re_q;
    it0.neg_im = neg_im_q;
    it0.big_re = al_re >= den_q;
    it0.big_im = al_im >= den_q;
    it0.d      = den_q;
    it0.r_re   = al_re;
    it0.r_im   = al_im;
    it0.nl_re  = {n_re_q[KSH-1:0], {FRAC_BITS{1'b0}}};
    it0.nl_im  = {n_im_q[KSH-1:0], {FRAC_BITS{1'b0}}};
    it0.q_re   = '0;
    it0.q_im   = '0;
    it0.sx     = den_q;
    it0.srem   = '0;
    it0.root   = '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      it_q[0] <= it0;
      for (int i = 1; i <= NSTEP; i++) begin
        it_q[i] <= step_fn(it_q[i-1]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      for (int i = 0; i <= NSTEP; i++) begin
        itv_q[i] <= 1'b0;
      end
    end else if (adv) begin
      v1_q     <= !q_empty_i;
      v2_q     <= v1_q;
      itv_q[0] <= v2_q;
      for (int i = 1; i <= NSTEP; i++) begin
        itv_q[i] <= itv_q[i-1];
      end
    end
  end

  // result formatting
  res_t fin;
  sat_t f_re, f_im;
  it_t  lst;

  always_comb begin
    lst  = it_q[NSTEP];
    f_re = div_fmt(lst.q_re, lst.neg_re, lst.big_re);
    f_im = div_fmt(lst.q_im, lst.neg_im, lst.big_im);
    case (lst.cls)
      CLS_DIV: begin
        if (lst.dz) begin
          fin = '{re: '0, im: '0, ovf: 1'b0, dz: 1'b1};
        end else begin
          fin = '{re: f_re.val, im: f_im.val, ovf: f_re.ovf | f_im.ovf, dz: 1'b0};
        end
      end
      CLS_MAG: begin
        fin = '{re: lst.root[31] ? S32_MAX : lst.root, im: '0, ovf: lst.root[31], dz: 1'b0};
      end
      default: begin
        fin = '{re: lst.sr, im: lst.si, ovf: lst.so, dz: 1'b0};
      end
    endcase
  end

  // two-word output buffer
  res_t       ob_q [2];
  logic       ob_wp_q, ob_rp_q;
  logic [1:0] ocnt_q;
  logic       ob_push, ob_pop;

  assign adv     = ocnt_q != 2'd2;
  assign take_o  = adv;
  assign ob_push = adv && itv_q[NSTEP];
  assign ob_pop  = pop_i && (ocnt_q != 2'd0);
  assign empty_o = ocnt_q == 2'd0;
  assign res_o   = ob_q[ob_rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_wp_q <= 1'b0;
      ob_rp_q <= 1'b0;
      ocnt_q  <= '0;
    end else begin
      if (ob_push) ob_wp_q <= !ob_wp_q;
      if (ob_pop)  ob_rp_q <= !ob_rp_q;
      ocnt_q <= ocnt_q + 2'(ob_push) - 2'(ob_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ob_push) begin
      ob_q[ob_wp_q] <= fin;
    end
  end

  `include "complex_arithmetic_unit_core_assert.svh"

  `CAU_ASSERT_NXT(a_hold, !adv, $stable(itv_q[NSTEP]), "pipeline moved while output buffer full")
  `CAU_ASSERT_IMP(a_mag_im, ob_push && (lst.cls == CLS_MAG), fin.im == '0, "magnitude with non-zero imaginary part")
  `CAU_ASSERT_NXT(a_count, ob_push && !ob_pop, ocnt_q == $past(ocnt_q) + 2'd1, "output word lost")

endmodule
`default_nettype wire

@@ rtl/complex_arithmetic_unit_core.sv @@
// Channel   Direction  Handshake         Words
// input     in         push / full       op, a_re, a_im, b_re, b_im
// result    out        empty / pop       res_re, res_im, overflow, div_by_zero
//
// Sustains one word per cycle in each direction while the result buffer is not
// full; a result passes through the 32 one-bit stages of the divider and
// square-root pipeline plus multiply, combine and set-up stages.
// rst_ni is asynchronous, active low, and empties both queues.
// While the two-word result buffer is full the whole back pipeline holds;
// the input queue then fills and full rises after at most four more words.
`default_nettype none
module complex_arithmetic_unit_core
  import cau_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  op_i,
  input  wire logic [31:0] a_re_i,
  input  wire logic [31:0] a_im_i,
  input  wire logic [31:0] b_re_i,
  input  wire logic [31:0] b_im_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      res_re_o,
  output logic [31:0]      res_im_o,
  output logic             overflow_o,
  output logic             div_by_zero_o
);

  logic  wr, take, q_empty;
  item_t item, head;
  res_t  res;

  // front: classify and write into the queue
  cau_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_i (full),
    .op_i   (op_i),
    .a_re_i (a_re_i),
    .a_im_i (a_im_i),
    .b_re_i (b_re_i),
    .b_im_i (b_im_i),
    .wr_o   (wr),
    .item_o (item)
  );

  // short queue that decouples front from back
  cau_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .item_i  (item),
    .take_i  (take),
    .full_o  (full),
    .empty_o (q_empty),
    .head_o  (head)
  );

  // back: arithmetic pipeline and result buffer
  cau_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_head_i  (head),
    .take_o    (take),
    .pop_i     (pop),
    .empty_o   (empty),
    .res_o     (res)
  );

  assign res_re_o      = res.re;
  assign res_im_o      = res.im;
  assign overflow_o    = res.ovf;
  assign div_by_zero_o = res.dz;

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cau_pkg::*;

  // Generous bound: 500 words plus directed ones, each with worst gaps and stalls.
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [2:0]  op_i = OP_ADD;
  logic [31:0] a_re_i = '0;
  logic [31:0] a_im_i = '0;
  logic [31:0] b_re_i = '0;
  logic [31:0] b_im_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] res_re_o;
  logic [31:0] res_im_o;
  logic        overflow_o;
  logic        div_by_zero_o;

  complex_arithmetic_unit_core dut (.*);

  res_t answers_due[$];
  int   n_errors = 0;
  int   cycle_cnt = 0;
  // sender burst control: words left in this burst, longest gap between bursts
  int   burst_left = 0;
  int   max_gap = 6;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Clamp a wide signed value into the 32-bit range, flagging saturation.
  function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout logic sat);
    if (v > 128'sh7fff_ffff) begin
      sat = 1'b1;
      return S32_MAX;
    end
    if (v < -128'sh8000_0000) begin
      sat = 1'b1;
      return S32_MIN;
    end
    return v[31:0];
  endfunction

  // Quotient |num| * 2^FRAC_BITS / den, truncated, then given the sign of num.
  function automatic logic [31:0] frac_quotient(input logic signed [127:0] num,
                                                input logic [127:0] den, inout logic sat);
    logic [127:0] mag;
    logic [127:0] q;
    mag = (num < 0) ? -num : num;
    q   = (mag << FRAC_BITS) / den;
    if (num < 0) begin
      if (q > 128'h8000_0000) begin
        sat = 1'b1;
        return S32_MIN;
      end
      return -q[31:0];
    end
    if (q > 128'h7fff_ffff) begin
      sat = 1'b1;
      return S32_MAX;
    end
    return q[31:0];
  endfunction

  function automatic logic [127:0] floor_sqrt(input logic [127:0] x);
    logic [127:0] root;
    logic [127:0] bitv;
    root = '0;
    bitv = 128'd1 << 126;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x    = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic res_t complex_result(input logic [2:0] op, input logic [31:0] ar,
                                          input logic [31:0] ai, input logic [31:0] br,
                                          input logic [31:0] bi);
    logic signed [127:0] xr, xi, yr, yi;
    logic [127:0]        den;
    res_t                r;
    xr = $signed(ar);
    xi = $signed(ai);
    yr = $signed(br);
    yi = $signed(bi);
    r  = '0;
    case (op)
      OP_ADD: begin
        r.re = clamp32(xr + yr, r.ovf);
        r.im = clamp32(xi + yi, r.ovf);
      end
      OP_SUB: begin
        r.re = clamp32(xr - yr, r.ovf);
        r.im = clamp32(xi - yi, r.ovf);
      end
      OP_MUL: begin
        r.re = clamp32((xr * yr - xi * yi) >>> FRAC_BITS, r.ovf);
        r.im = clamp32((xr * yi + xi * yr) >>> FRAC_BITS, r.ovf);
      end
      OP_DIV: begin
        den = xr * 0 + yr * yr + yi * yi;
        if (den == 0) begin
          r.dz = 1'b1;
        end else begin
          r.re = frac_quotient(xr * yr + xi * yi, den, r.ovf);
          r.im = frac_quotient(xi * yr - xr * yi, den, r.ovf);
        end
      end
      OP_SCALE: begin
        r.re = clamp32((xr * yr) >>> FRAC_BITS, r.ovf);
        r.im = clamp32((xi * yr) >>> FRAC_BITS, r.ovf);
      end
      OP_MAG: begin
        den  = floor_sqrt(xr * xr + xi * xi);
        if (den > 128'h7fff_ffff) begin
          r.ovf = 1'b1;
          r.re  = S32_MAX;
        end else begin
          r.re = den[31:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Predict at acceptance: sample pre-edge values of the handshake.
  always @(posedge clk_i) begin
    if (rst_ni && push && !full)
      answers_due.push_back(complex_result(op_i, a_re_i, a_im_i, b_re_i, b_im_i));
  end

  // Check each result word taken against the oldest prediction.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && pop && !empty) begin
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected result re=%h im=%h", $time, res_re_o, res_im_o);
        n_errors++;
      end else begin
        want = answers_due.pop_front();
        if (res_re_o !== want.re) begin
          $display("%0t: res_re expected %h actual %h", $time, want.re, res_re_o);
          n_errors++;
        end
        if (res_im_o !== want.im) begin
          $display("%0t: res_im expected %h actual %h", $time, want.im, res_im_o);
          n_errors++;
        end
        if (overflow_o !== want.ovf) begin
          $display("%0t: overflow expected %b actual %b", $time, want.ovf, overflow_o);
          n_errors++;
        end
        if (div_by_zero_o !== want.dz) begin
          $display("%0t: div_by_zero expected %b actual %b", $time, want.dz, div_by_zero_o);
          n_errors++;
        end
      end
    end
  end

  // Receiver: hold pop at one level for a random stretch; long stretches of
  // continuous pop alternate with stalls of varying length.
  always @(posedge clk_i) begin
    int stretch;
    if (stretch > 0) begin
      stretch--;
    end else begin
      case ($urandom_range(0, 3))
        0: begin pop <= 1'b1; stretch = $urandom_range(20, 120); end
        1: begin pop <= 1'b0; stretch = $urandom_range(1, 40); end
        default: begin pop <= $urandom_range(0, 1); stretch = $urandom_range(0, 4); end
      endcase
    end
  end

  // Abort on a hung run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Present one word and hold it until taken; drop push between bursts.
  task automatic send_word(input logic [2:0] op, input logic [31:0] ar,
                           input logic [31:0] ai, input logic [31:0] br,
                           input logic [31:0] bi);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    push   <= 1'b1;
    op_i   <= op;
    a_re_i <= ar;
    a_im_i <= ai;
    b_re_i <= br;
    b_im_i <= bi;
    do @(posedge clk_i); while (full);
    burst_left--;
  endtask

  // Operand mix: extremes, small Q16.16 values, and fully random words.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return S32_MAX;
      1: return S32_MIN;
      2: return '0;
      3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
      4: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      5: return $urandom & 32'h00ff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_word(OP_ADD, S32_MAX, S32_MIN, S32_MAX, S32_MIN);
    send_word(OP_ADD, 32'h0001_8000, 32'hffff_0000, 32'h0000_8000, 32'h0002_0000);
    send_word(OP_SUB, S32_MIN, S32_MAX, S32_MAX, S32_MIN);
    send_word(OP_SUB, 32'h0003_0000, '0, 32'h0001_0000, 32'hffff_ffff);
    send_word(OP_MUL, S32_MIN, S32_MIN, S32_MIN, S32_MAX);
    send_word(OP_MUL, 32'h0002_0000, 32'h0001_0000, 32'hffff_8000, 32'h0000_0001);
    send_word(OP_MUL, 32'hffff_ffff, '0, 32'h0000_0001, '0);
    // divide by zero, with and without a zero numerator
    send_word(OP_DIV, 32'h1234_5678, S32_MIN, '0, '0);
    send_word(OP_DIV, '0, '0, '0, '0);
    send_word(OP_DIV, 32'h0004_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
    send_word(OP_DIV, S32_MAX, S32_MIN, 32'h0000_0001, '0);
    send_word(OP_DIV, S32_MIN, S32_MIN, S32_MIN, S32_MIN);
    send_word(OP_DIV, 32'hffff_ffff, 32'h0000_0001, 32'h7fff_0000, S32_MIN);
    send_word(OP_SCALE, S32_MIN, S32_MAX, S32_MIN, 32'h5555_5555);
    send_word(OP_SCALE, 32'h0003_0000, 32'hfffd_0000, 32'h0000_8000, '0);
    // magnitude too large saturates; small and zero magnitudes
    send_word(OP_MAG, S32_MIN, S32_MIN, '0, '0);
    send_word(OP_MAG, S32_MAX, '0, 32'hffff_ffff, '0);
    send_word(OP_MAG, 32'h0003_0000, 32'hfffc_0000, '0, '0);
    send_word(OP_MAG, '0, '0, '0, '0);
    // unused opcodes give zeros and no flags
    send_word(3'd6, S32_MAX, S32_MIN, '0, '0);
    send_word(3'd7, '1, '1, '1, '1);
  endtask

  task automatic test_random_ops(input int n_words);
    logic [2:0] op;
    repeat (n_words) begin
      op = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      send_word(op, pick_operand(), pick_operand(), pick_operand(), pick_operand());
    end
  endtask

  task automatic test_back_to_back(input int n_words);
    // no gaps on the sender side: keep the pipeline full
    max_gap    = 0;
    burst_left = n_words;
    test_random_ops(n_words);
    max_gap = 6;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_ops(300);
    test_back_to_back(100);
    max_gap = 40;
    test_random_ops(100);
    push <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+rtl
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_queue.sv
rtl/cau_back.sv
rtl/complex_arithmetic_unit_core.sv
test/tb_top.sv
